// File: sv/elevation_cell_fusion_unit_macros.svh
// ----------------------------------------------------------------------------
// Elevation cell fusion assertion macros
// Shared concurrent assertion forms, clocked on clk_i, gated by rst_ni.
// ----------------------------------------------------------------------------
`ifndef ELEVATION_CELL_FUSION_UNIT_MACROS_SVH
`define ELEVATION_CELL_FUSION_UNIT_MACROS_SVH

// plain property, off during reset
`define ECF_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// same-cycle implication
`define ECF_ASSERT_IMP(lbl, ante, cons, msg) \
  `ECF_ASSERT(lbl, (ante) |-> (cons), msg)

// next-cycle implication
`define ECF_ASSERT_NXT(lbl, ante, cons, msg) \
  `ECF_ASSERT(lbl, (ante) |=> (cons), msg)

`endif

// File: sv/ecf_pkg.sv
// ----------------------------------------------------------------------------
// Elevation cell fusion package
// Cell word layout, outcome codes, register indexes and defaults.
// ----------------------------------------------------------------------------
package ecf_pkg;

  localparam int unsigned NumCellsDefault = 1024;

  localparam logic [31:0] MeasVarReset  = 32'd966368;
  localparam logic [31:0] OffsetReset   = 32'd0;
  localparam logic [30:0] MinRangeReset = 31'd32768;
  localparam logic [4:0]  JumpLimReset  = 5'd10;
  localparam logic [4:0]  JumpSat       = 5'd20;

  localparam logic [1:0] REG_MEAS_VAR  = 2'd0;
  localparam logic [1:0] REG_OFFSET    = 2'd1;
  localparam logic [1:0] REG_MIN_RANGE = 2'd2;
  localparam logic [1:0] REG_JUMP_LIM  = 2'd3;

  localparam logic [2:0] OC_SKIP    = 3'd0;
  localparam logic [2:0] OC_INIT    = 3'd1;
  localparam logic [2:0] OC_JUMP    = 3'd2;
  localparam logic [2:0] OC_REPLACE = 3'd3;
  localparam logic [2:0] OC_REJECT  = 3'd4;
  localparam logic [2:0] OC_FUSED   = 3'd5;

  typedef struct packed {
    logic               valid;
    logic [4:0]         jumps;
    logic [31:0]        variance;
    logic signed [31:0] height;
  } cell_t;

  localparam int unsigned CellW = $bits(cell_t);

endpackage

// File: sv/elevation_cell_fusion_unit.sv
// ----------------------------------------------------------------------------
// Elevation cell fusion unit
// Per-point variance-weighted update of a grid elevation map held in RAM.
// ----------------------------------------------------------------------------
//  channel | dir | handshake               | payload
//  in      | in  | in_valid_i / in_ready_o | cell_index, in_map, sensor_x/y/z, world_height
//  out     | out | out_valid_o/out_ready_i | outcome, cell_elevation/variance/jump_count
//  cfg     | in  | cfg_we_i                | cfg_idx_i, cfg_wdata_i
//
// One request at a time. Skip, init, jump and reject go from the decision
// state to the output; a fused point also runs two 30-step square-root
// iterations side by side and a 32-step radix-2 divider.
// After reset a clearing pass writes every cell before the first
// request is taken. A result waiting on out_ready_i holds the next request
// in its final state.
module elevation_cell_fusion_unit
  import ecf_pkg::*;
#(
  parameter int unsigned NUM_CELLS = NumCellsDefault
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [1:0]         cfg_idx_i,
  input  logic [31:0]        cfg_wdata_i,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [9:0]         cell_index_i,
  input  logic               in_map_i,
  input  logic signed [31:0] sensor_x_i,
  input  logic signed [31:0] sensor_y_i,
  input  logic signed [31:0] sensor_z_i,
  input  logic signed [31:0] world_height_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [2:0]         outcome_o,
  output logic signed [31:0] cell_elevation_o,
  output logic [31:0]        cell_variance_o,
  output logic [4:0]         cell_jump_count_o
);

  localparam int unsigned AW = $clog2(NUM_CELLS);

  localparam logic [3:0] ST_CLR  = 4'd0;
  localparam logic [3:0] ST_IDLE = 4'd1;
  localparam logic [3:0] ST_X    = 4'd2;
  localparam logic [3:0] ST_Y    = 4'd3;
  localparam logic [3:0] ST_Z    = 4'd4;
  localparam logic [3:0] ST_R    = 4'd5;
  localparam logic [3:0] ST_D2   = 4'd6;
  localparam logic [3:0] ST_DEC  = 4'd7;
  localparam logic [3:0] ST_SQ   = 4'd8;
  localparam logic [3:0] ST_DS   = 4'd9;
  localparam logic [3:0] ST_DIV  = 4'd10;
  localparam logic [3:0] ST_M1   = 4'd11;
  localparam logic [3:0] ST_M2   = 4'd12;
  localparam logic [3:0] ST_M3   = 4'd13;
  localparam logic [3:0] ST_FIN  = 4'd14;
  localparam logic [3:0] ST_OUT  = 4'd15;

  logic [3:0] state_q, state_d;
  logic [AW-1:0] clr_cnt_q;
  logic [4:0] cnt_q;

  logic [31:0] mv_q;
  logic signed [31:0] off_q;
  logic [30:0] mr_q;
  logic [4:0] jl_q;

  logic [9:0] idx_q;
  logic inmap_q;
  logic [31:0] ax_q, ay_q, az_q;
  logic signed [31:0] h_q;
  cell_t cell_q;
  logic d_neg_q;
  logic [32:0] ad_q;
  logic [63:0] acc_q;
  logic [61:0] mr2_q;
  logic [35:0] dd_q;
  logic [67:0] prod_q;

  logic [59:0] sqa_op_q, sqb_op_q;
  logic [33:0] sqa_rem_q, sqb_rem_q;
  logic [29:0] sqa_root_q, sqb_root_q;
  logic [30:0] s_q, div_rem_q;
  logic [31:0] r_q, g_q;
  logic [33:0] p1_q;
  logic [30:0] t_q;

  logic [2:0] res_oc_q;
  cell_t res_q;

  logic out_valid_q;
  logic [2:0] out_oc_q;
  cell_t out_cell_q;

  logic mem_we;
  logic [AW-1:0] mem_addr;
  cell_t mem_wdata, mem_rdata;

  logic accept;
  logic [31:0] rvar;
  logic [35:0] mul_a;
  logic [31:0] mul_b;
  logic signed [32:0] h_sum, d_full;
  logic signed [31:0] h_sat;
  logic in_range, dev, jump_hit;
  logic [4:0] j_inc;
  cell_t dec_word, fin_word;
  logic dec_we;
  logic [2:0] dec_oc;
  logic [17:0] stepv;
  logic [33:0] p2;
  logic [31:0] rem2;
  logic wr_state;

  function automatic logic [31:0] mag32(input logic signed [31:0] v);
    mag32 = v[31] ? 32'(-v) : 32'(v);
  endfunction

  function automatic logic [63:0] sq_step(input logic [33:0] rem, input logic [29:0] root,
                                          input logic [1:0] top2);
    logic [33:0] sh, trial;
    sh    = {rem[31:0], top2};
    trial = {2'b00, root, 2'b01};
    if (sh >= trial) begin
      sq_step = {sh - trial, root[28:0], 1'b1};
    end else begin
      sq_step = {sh, root[28:0], 1'b0};
    end
  endfunction

  assign accept     = in_valid_i && in_ready_o;
  assign in_ready_o = (state_q == ST_IDLE);
  assign rvar       = (mv_q == 32'd0) ? 32'd1 : mv_q;

  assign h_sum = 33'(world_height_i) + 33'(off_q);
  assign h_sat = (h_sum[32] != h_sum[31]) ? (h_sum[32] ? 32'sh8000_0000 : 32'sh7FFF_FFFF)
                                          : h_sum[31:0];
  assign d_full = 33'(h_q) - 33'(cell_q.height);

  ecf_ram #(
    .Width(CellW),
    .Depth(NUM_CELLS)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (mem_we),
    .addr_i (mem_addr),
    .wdata_i(mem_wdata),
    .rdata_o(mem_rdata)
  );

  always_comb begin
    case (state_q)
      ST_CLR:  mem_addr = clr_cnt_q;
      ST_IDLE: mem_addr = AW'(cell_index_i);
      default: mem_addr = AW'(idx_q);
    endcase
  end

  // shared multiplier operands
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_q)
      ST_X:   begin mul_a = 36'(ax_q); mul_b = ax_q; end
      ST_Y:   begin mul_a = 36'(ay_q); mul_b = ay_q; end
      ST_Z:   begin mul_a = 36'(az_q); mul_b = az_q; end
      ST_R:   begin mul_a = 36'(mr_q); mul_b = 32'(mr_q); end
      ST_D2:  begin mul_a = 36'(ad_q[17:0]); mul_b = 32'(ad_q[17:0]); end
      ST_DS:  begin mul_a = 36'(sqa_root_q); mul_b = 32'(sqb_root_q); end
      ST_M1:  begin mul_a = 36'(r_q); mul_b = r_q; end
      ST_M2:  begin mul_a = dd_q; mul_b = 32'(r_q[31:16]); end
      ST_M3:  begin mul_a = 36'(ad_q[17:0]); mul_b = g_q; end
      default: begin mul_a = '0; mul_b = '0; end
    endcase
  end

  // decision on the fetched cell
  always_comb begin
    in_range = (32'(idx_q) < 32'(NUM_CELLS));
    dev      = (ad_q >= 33'h4_0000) || (prod_q[35:0] > {cell_q.variance, 4'b0000});
    j_inc    = (cell_q.jumps < JumpSat) ? cell_q.jumps + 5'd1 : cell_q.jumps;
    jump_hit = (j_inc > jl_q);
    dec_we   = 1'b0;
    dec_oc   = OC_SKIP;
    dec_word = cell_q;
    if (!in_range) begin
      dec_word = '0;
    end else if (!inmap_q || (acc_q < 64'(mr2_q))) begin
      dec_word = cell_q.valid ? cell_q : '0;
    end else if (!cell_q.valid) begin
      dec_we   = 1'b1;
      dec_oc   = OC_INIT;
      dec_word = '{valid: 1'b1, jumps: 5'd1, variance: rvar, height: h_q};
    end else if (dev && !d_neg_q) begin
      dec_we = 1'b1;
      if (jump_hit) begin
        dec_oc   = OC_REPLACE;
        dec_word = '{valid: 1'b1, jumps: 5'd0, variance: rvar, height: h_q};
      end else begin
        dec_oc         = OC_JUMP;
        dec_word.jumps = j_inc;
      end
    end else if (dev && d_neg_q) begin
      dec_oc = OC_REJECT;
    end else begin
      dec_oc = OC_FUSED;
    end
  end

  // ad*g lands in prod_q during ST_FIN
  always_comb begin
    stepv    = prod_q[49:32];
    p2       = (p1_q > 34'(t_q)) ? p1_q - 34'(t_q) : 34'd1;
    fin_word = cell_q;
    fin_word.variance = (p2[33:32] != 2'b00) ? 32'hFFFF_FFFF : p2[31:0];
    fin_word.height   = d_neg_q ? cell_q.height - 32'(stepv)
                                : cell_q.height + 32'(stepv);
    rem2 = {div_rem_q, 1'b0};
  end

  always_comb begin
    mem_we    = 1'b0;
    mem_wdata = '0;
    case (state_q)
      ST_CLR: mem_we = 1'b1;
      ST_DEC: begin
        mem_we    = dec_we;
        mem_wdata = dec_word;
      end
      ST_FIN: begin
        mem_we    = 1'b1;
        mem_wdata = fin_word;
      end
      default: mem_we = 1'b0;
    endcase
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_CLR:  if (clr_cnt_q == AW'(NUM_CELLS - 1)) state_d = ST_IDLE;
      ST_IDLE: if (accept) state_d = ST_X;
      ST_X:    state_d = ST_Y;
      ST_Y:    state_d = ST_Z;
      ST_Z:    state_d = ST_R;
      ST_R:    state_d = ST_D2;
      ST_D2:   state_d = ST_DEC;
      ST_DEC:  state_d = (in_range && dec_oc == OC_FUSED) ? ST_SQ : ST_OUT;
      ST_SQ:   if (cnt_q == 5'd29) state_d = ST_DS;
      ST_DS:   state_d = ST_DIV;
      ST_DIV:  if (cnt_q == 5'd31) state_d = ST_M1;
      ST_M1:   state_d = ST_M2;
      ST_M2:   state_d = ST_M3;
      ST_M3:   state_d = ST_FIN;
      ST_FIN:  state_d = ST_OUT;
      ST_OUT:  if (!out_valid_q || out_ready_i) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLR;
      clr_cnt_q   <= '0;
      cnt_q       <= '0;
      mv_q        <= MeasVarReset;
      off_q       <= OffsetReset;
      mr_q        <= MinRangeReset;
      jl_q        <= JumpLimReset;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == ST_CLR) begin
        clr_cnt_q <= clr_cnt_q + AW'(1);
      end
      if (state_q == ST_SQ || state_q == ST_DIV) begin
        cnt_q <= cnt_q + 5'd1;
      end else begin
        cnt_q <= '0;
      end
      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_MEAS_VAR:  mv_q  <= cfg_wdata_i;
          REG_OFFSET:    off_q <= cfg_wdata_i;
          REG_MIN_RANGE: mr_q  <= cfg_wdata_i[30:0];
          REG_JUMP_LIM:  jl_q  <= cfg_wdata_i[4:0];
          default:       mv_q  <= mv_q;
        endcase
      end
      if (state_q == ST_OUT && (!out_valid_q || out_ready_i)) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q <= 68'(mul_a * 68'(mul_b));
    if (accept) begin
      idx_q   <= cell_index_i;
      inmap_q <= in_map_i;
      ax_q    <= mag32(sensor_x_i);
      ay_q    <= mag32(sensor_y_i);
      az_q    <= mag32(sensor_z_i);
      h_q     <= h_sat;
    end
    case (state_q)
      ST_X: cell_q <= mem_rdata;
      ST_Y: begin
        acc_q   <= prod_q[63:0];
        d_neg_q <= d_full[32];
        ad_q    <= d_full[32] ? 33'(-d_full) : 33'(d_full);
      end
      ST_Z:  acc_q <= acc_q + prod_q[63:0];
      ST_R:  acc_q <= acc_q + prod_q[63:0];
      ST_D2: mr2_q <= prod_q[61:0];
      ST_DEC: begin
        dd_q     <= prod_q[35:0];
        res_oc_q <= dec_oc;
        res_q    <= dec_word;
        sqa_op_q   <= {rvar, 28'd0};
        sqb_op_q   <= {cell_q.variance, 28'd0};
        sqa_rem_q  <= '0;
        sqb_rem_q  <= '0;
        sqa_root_q <= '0;
        sqb_root_q <= '0;
      end
      ST_SQ: begin
        {sqa_rem_q, sqa_root_q} <= sq_step(sqa_rem_q, sqa_root_q, sqa_op_q[59:58]);
        {sqb_rem_q, sqb_root_q} <= sq_step(sqb_rem_q, sqb_root_q, sqb_op_q[59:58]);
        sqa_op_q <= {sqa_op_q[57:0], 2'b00};
        sqb_op_q <= {sqb_op_q[57:0], 2'b00};
      end
      ST_DS: begin
        s_q       <= 31'(sqa_root_q) + 31'(sqb_root_q);
        div_rem_q <= 31'(sqb_root_q);
        r_q       <= '0;
      end
      ST_DIV: begin
        // a*b from ST_DS is in prod_q on the first divider step
        if (cnt_q == 5'd0) begin
          p1_q <= prod_q[61:28];
        end
        if (rem2 >= {1'b0, s_q}) begin
          div_rem_q <= 31'(rem2 - {1'b0, s_q});
          r_q       <= {r_q[30:0], 1'b1};
        end else begin
          div_rem_q <= rem2[30:0];
          r_q       <= {r_q[30:0], 1'b0};
        end
      end
      ST_M2: g_q     <= prod_q[63:32];
      ST_M3: t_q     <= prod_q[51:21];
      ST_FIN: begin
        res_q <= fin_word;
      end
      default: cell_q <= cell_q;
    endcase
    if (state_q == ST_OUT && (!out_valid_q || out_ready_i)) begin
      out_oc_q   <= res_oc_q;
      out_cell_q <= res_q;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign outcome_o         = out_oc_q;
  assign cell_elevation_o  = out_cell_q.height;
  assign cell_variance_o   = out_cell_q.variance;
  assign cell_jump_count_o = out_cell_q.jumps;

  assign wr_state = (state_q == ST_CLR) || (state_q == ST_DEC) || (state_q == ST_FIN);

`include "elevation_cell_fusion_unit_macros.svh"

  `ECF_ASSERT_IMP(a_we_states, mem_we, wr_state, "RAM write outside a write state")
  `ECF_ASSERT_NXT(a_accept_fetch, accept, (state_q == ST_X), "accept without fetch")
  `ECF_ASSERT_IMP(a_out_code, out_valid_o, (outcome_o <= OC_FUSED), "outcome out of range")
  `ECF_ASSERT_IMP(a_div_nonzero, (state_q == ST_DIV), (s_q != 31'd0), "zero divisor")

endmodule

// File: sv/ecf_ram.sv
// ----------------------------------------------------------------------------
// Elevation cell fusion RAM
// Generic single-port synchronous RAM with registered read.
// ----------------------------------------------------------------------------
module ecf_ram
  import ecf_pkg::*;
#(
  parameter int unsigned Width = CellW,
  parameter int unsigned Depth = NumCellsDefault
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] addr_i,
  input  logic [Width-1:0]         wdata_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_o <= mem_q[addr_i];
  end

endmodule
